### hw/rtl/bsst_pkg.sv
// bsst_pkg: shared types and constants for the sorted table search block
// no dependencies; used by the interfaces, the top level, the checker and the testbench

package bsst_pkg;

   localparam int KEY_WIDTH   = 32;
   localparam int INDEX_WIDTH = 8;
   localparam int COUNT_WIDTH = 9;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROBE,
      ST_COMPARE,
      ST_DONE
   } state_type;

endpackage

### hw/rtl/bsst_req_if.sv
// bsst_req_if: request channel (valid/ready) carrying table writes and searches
// depends on bsst_pkg for field widths

interface bsst_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 operation;
   logic [bsst_pkg::INDEX_WIDTH-1:0]     entry_index;
   logic signed [bsst_pkg::KEY_WIDTH-1:0] value;

   modport source (output valid, output operation, output entry_index, output value,
                   input ready);
   modport sink   (input valid, input operation, input entry_index, input value,
                   output ready);
endinterface

### hw/rtl/bsst_rsp_if.sv
// bsst_rsp_if: response channel (valid/ready) carrying search results
// depends on bsst_pkg for field widths

interface bsst_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             found;
   logic [bsst_pkg::INDEX_WIDTH-1:0] match_index;

   modport source (output valid, output found, output match_index, input ready);
   modport sink   (input valid, input found, input match_index, output ready);
endinterface

### hw/rtl/bsst_ram.sv
// bsst_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies

module bsst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/binary_search_sorted_table.sv
// binary_search_sorted_table: table search top, uses bsst_pkg, bsst_ram and both channel ifs
// a write is taken in ST_IDLE, gives no response and leaves the block ready for the next request;
// a search runs probes, each a ram read (ST_PROBE) then a compare (ST_COMPARE), until a hit or
// an empty window, then loads the response in ST_DONE; no request is taken until ST_IDLE again;
// the load waits while the previous response is still held by the receiver
// reset (synchronous, active high) clears the controller, response valid and entries_ff

module binary_search_sorted_table #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [bsst_pkg::COUNT_WIDTH-1:0] csr_wr_data,
   bsst_req_if.sink                         req_ch,
   bsst_rsp_if.source                       rsp_ch
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int KW = bsst_pkg::KEY_WIDTH;
   localparam int IW = bsst_pkg::INDEX_WIDTH;

   bsst_pkg::state_type state_ff, state_in;

   logic [bsst_pkg::COUNT_WIDTH-1:0] entries_ff;
   logic [CW-1:0]                    low_ff, low_in;
   logic [CW-1:0]                    hi_ex_ff, hi_ex_in;   // window end, exclusive
   logic [CW-1:0]                    mid_ff, mid_in;
   logic signed [KW-1:0]             key_ff, key_in;
   logic                             hit_ff, hit_in;

   logic                             rsp_valid_ff;
   logic                             rsp_found_ff;
   logic [IW-1:0]                    rsp_index_ff;

   logic                             req_accept;
   logic                             rsp_take;
   logic                             rsp_load;
   logic                             ram_wr_en;
   logic                             ram_rd_en;
   logic [AW-1:0]                    ram_wr_addr;
   logic [AW-1:0]                    ram_rd_addr;
   logic [KW-1:0]                    ram_rd_data;
   logic signed [KW-1:0]             entry;

   logic [CW:0]                      mid_sum;
   logic [CW-1:0]                    mid_now;
   logic [CW-1:0]                    count;
   logic [AW+IW-1:0]                 wr_idx_ext;
   logic [CW+IW-1:0]                 mid_idx_ext;
   logic                             wr_in_range;

   assign req_accept = req_ch.valid && req_ch.ready;
   assign rsp_take   = rsp_valid_ff && rsp_ch.ready;

   // saturate the search count at the table depth
   assign count = (32'(entries_ff) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(entries_ff);

   assign mid_sum = {1'b0, low_ff} + {1'b0, hi_ex_ff} - (CW + 1)'(1);
   assign mid_now = mid_sum[CW:1];

   assign wr_idx_ext  = {{AW{1'b0}}, req_ch.entry_index};
   assign wr_in_range = 32'(req_ch.entry_index) < TABLE_DEPTH;
   assign mid_idx_ext = {{IW{1'b0}}, mid_ff};
   assign entry       = $signed(ram_rd_data);

   bsst_ram #(
      .WIDTH (KW),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_ch.value),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bsst_pkg::ST_IDLE: begin
            if (req_accept && req_ch.operation == bsst_pkg::OP_SEARCH) begin
               state_in = bsst_pkg::ST_PROBE;
            end
         end
         bsst_pkg::ST_PROBE: begin
            state_in = (low_ff < hi_ex_ff) ? bsst_pkg::ST_COMPARE : bsst_pkg::ST_DONE;
         end
         bsst_pkg::ST_COMPARE: begin
            state_in = (entry == key_ff) ? bsst_pkg::ST_DONE : bsst_pkg::ST_PROBE;
         end
         bsst_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               state_in = bsst_pkg::ST_IDLE;
            end
         end
         default: state_in = bsst_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_ch.ready = 1'b0;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      ram_wr_addr  = wr_idx_ext[AW-1:0];
      ram_rd_addr  = mid_now[AW-1:0];
      rsp_load     = 1'b0;
      low_in       = low_ff;
      hi_ex_in     = hi_ex_ff;
      mid_in       = mid_ff;
      key_in       = key_ff;
      hit_in       = hit_ff;
      case (state_ff)
         bsst_pkg::ST_IDLE: begin
            req_ch.ready = 1'b1;
            ram_wr_en    = req_ch.valid && req_ch.operation == bsst_pkg::OP_WRITE &&
                           wr_in_range;
            if (req_ch.valid && req_ch.operation == bsst_pkg::OP_SEARCH) begin
               low_in   = '0;
               hi_ex_in = count;
               key_in   = req_ch.value;
               hit_in   = 1'b0;
            end
         end
         bsst_pkg::ST_PROBE: begin
            if (low_ff < hi_ex_ff) begin
               ram_rd_en = 1'b1;
               mid_in    = mid_now;
            end
         end
         bsst_pkg::ST_COMPARE: begin
            if (entry == key_ff) begin
               hit_in = 1'b1;
            end else if (key_ff < entry) begin
               hi_ex_in = mid_ff;
            end else begin
               low_in = mid_ff + CW'(1);
            end
         end
         bsst_pkg::ST_DONE: begin
            rsp_load = !rsp_valid_ff || rsp_ch.ready;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bsst_pkg::ST_IDLE;
         entries_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            entries_ff <= csr_wr_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_take) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      low_ff   <= low_in;
      hi_ex_ff <= hi_ex_in;
      mid_ff   <= mid_in;
      key_ff   <= key_in;
      hit_ff   <= hit_in;
      if (rsp_load) begin
         rsp_found_ff <= hit_ff;
         rsp_index_ff <= hit_ff ? mid_idx_ext[IW-1:0] : '0;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.found       = rsp_found_ff;
   assign rsp_ch.match_index = rsp_index_ff;

   // a probe is only compared while the window still holds it
   assert property (@(posedge clock) disable iff (reset)
      state_ff == bsst_pkg::ST_COMPARE |-> (low_ff <= mid_ff) && (mid_ff < hi_ex_ff))
      else $error("probe outside search window");

   assert property (@(posedge clock) disable iff (reset)
      state_ff != bsst_pkg::ST_IDLE |-> 32'(hi_ex_ff) <= TABLE_DEPTH)
      else $error("search window beyond table depth");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |-> rsp_index_ff == '0)
      else $error("miss reported with non-zero index");

   assert property (@(posedge clock) disable iff (reset)
      req_accept && req_ch.operation == bsst_pkg::OP_SEARCH |=>
         state_ff == bsst_pkg::ST_PROBE && !hit_ff)
      else $error("search transaction did not start a probe");

   assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> state_ff == bsst_pkg::ST_IDLE && !ram_rd_en)
      else $error("table write during a search");

endmodule

### tb/bsst_search_checker.sv
// bsst_search_checker: shadows the table and entry count of binary_search_sorted_table,
// predicts every search answer and compares it with the response channel
// depends on bsst_pkg, bsst_req_if and bsst_rsp_if

module bsst_search_checker #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [bsst_pkg::COUNT_WIDTH-1:0] csr_wr_data,
   bsst_req_if                              req_ch,
   bsst_rsp_if                              rsp_ch,
   output int                               fail_count,
   output int                               pending,
   output int                               hit_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int   KEY_WIDTH   = bsst_pkg::KEY_WIDTH;
   localparam int   INDEX_WIDTH = bsst_pkg::INDEX_WIDTH;
   localparam int   COUNT_WIDTH = bsst_pkg::COUNT_WIDTH;
   localparam logic OP_WRITE    = bsst_pkg::OP_WRITE;

   typedef struct packed {
      logic                   found;
      logic [INDEX_WIDTH-1:0] match_index;
   } answer_type;

   logic signed [KEY_WIDTH-1:0] shadow_entries [TABLE_DEPTH];
   logic [COUNT_WIDTH-1:0]      shadow_count;
   answer_type                  awaited_answers [$];

   // truncating midpoint over the low..high window, first matching probe wins
   function automatic answer_type lookup_key(input logic signed [KEY_WIDTH-1:0] key);
      answer_type ans;
      int         span;
      int         low;
      int         high;
      int         mid;
      span = (int'(shadow_count) > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_count);
      ans  = '0;
      low  = 0;
      high = span - 1;
      while (low <= high) begin
         mid = (low + high) / 2;
         if (shadow_entries[mid] == key) begin
            ans.found       = 1'b1;
            ans.match_index = INDEX_WIDTH'(mid);
            break;
         end else if (key < shadow_entries[mid]) begin
            high = mid - 1;
         end else begin
            low = mid + 1;
         end
      end
      return ans;
   endfunction

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         shadow_count = '0;
         awaited_answers.delete();
         fail_count = 0;
         hit_count  = 0;
      end else begin
         if (csr_wr_en)
            shadow_count = csr_wr_data;
         if (req_ch.valid && req_ch.ready) begin
            if (req_ch.operation == OP_WRITE) begin
               if (int'(req_ch.entry_index) < TABLE_DEPTH)
                  shadow_entries[req_ch.entry_index] = req_ch.value;
            end else begin
               awaited_answers.push_back(lookup_key(req_ch.value));
            end
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_answers.size() == 0) begin
               $display("%0t: response with nothing awaited, actual found %0b index %0d",
                        $time, rsp_ch.found, rsp_ch.match_index);
               fail_count++;
            end else begin
               want = awaited_answers.pop_front();
               if (rsp_ch.found !== want.found) begin
                  $display("%0t: found mismatch, expected %0b actual %0b",
                           $time, want.found, rsp_ch.found);
                  fail_count++;
               end
               if (rsp_ch.match_index !== want.match_index) begin
                  $display("%0t: match_index mismatch, expected %0d actual %0d",
                           $time, want.match_index, rsp_ch.match_index);
                  fail_count++;
               end
               if (want.found)
                  hit_count++;
            end
         end
      end
      pending = awaited_answers.size();
   end

endmodule

### tb/tb_binary_search_sorted_table.sv
// tb_binary_search_sorted_table: stimulus and verdict for binary_search_sorted_table
// loads sorted, duplicate-heavy and unsorted tables, then searches them under random stalls
// depends on bsst_pkg, bsst_req_if, bsst_rsp_if, the block and bsst_search_checker

module tb_binary_search_sorted_table;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int   KEY_WIDTH   = bsst_pkg::KEY_WIDTH;
   localparam int   INDEX_WIDTH = bsst_pkg::INDEX_WIDTH;
   localparam int   COUNT_WIDTH = bsst_pkg::COUNT_WIDTH;
   localparam logic OP_WRITE    = bsst_pkg::OP_WRITE;
   localparam logic OP_SEARCH   = bsst_pkg::OP_SEARCH;

   localparam int TABLE_DEPTH    = 256;
   localparam int DIRECTED_ITEMS = 19;
   localparam int RANDOM_ITEMS   = 1900;
   localparam int TOTAL_ITEMS    = DIRECTED_ITEMS + RANDOM_ITEMS;
   localparam int CYCLE_LIMIT    = 500000;
   localparam int SETTLE_CYCLES  = 24;
   localparam logic signed [KEY_WIDTH-1:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [KEY_WIDTH-1:0] KEY_MAX = 32'sh7fff_ffff;
   localparam logic signed [KEY_WIDTH-1:0] SEED_ROW [7] =
      '{KEY_MIN, -32'sd5, 32'sd0, 32'sd7, 32'sd7, 32'sd7, KEY_MAX};

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [COUNT_WIDTH-1:0] csr_wr_data;

   bsst_req_if req_ch ();
   bsst_rsp_if rsp_ch ();

   int fail_count;
   int pending;
   int hit_count;
   int tx_idle_pct    = 33;
   int rx_idle_pct    = 51;
   int items_sent     = 0;
   int searches_sent  = 0;
   int count_settings = 0;
   int cycle_count    = 0;
   int current_span   = 0;

   // what the table holds from the stimulus side, used to aim keys at entries
   logic signed [KEY_WIDTH-1:0] loaded_values [TABLE_DEPTH];

   binary_search_sorted_table #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch)
   );

   bsst_search_checker #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) i_checker (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .fail_count  (fail_count),
      .pending     (pending),
      .hit_count   (hit_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("run stopped after %0d cycles with %0d answers outstanding",
                  cycle_count, pending);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock)
      rsp_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);

   task automatic drive_request(input logic op, input logic [INDEX_WIDTH-1:0] idx,
                                input logic signed [KEY_WIDTH-1:0] val);
      int gap;
      if (items_sent < TOTAL_ITEMS / 3) begin
         tx_idle_pct = 33;
         rx_idle_pct = 51;
      end else if (items_sent < 2 * TOTAL_ITEMS / 3) begin
         tx_idle_pct = 51;
         rx_idle_pct = 33;
      end else begin
         tx_idle_pct = 0;
         rx_idle_pct = 0;
      end
      gap = 0;
      while ($urandom_range(0, 99) < tx_idle_pct)
         gap++;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.operation   <= op;
      req_ch.entry_index <= idx;
      req_ch.value       <= val;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      items_sent++;
      if (op == OP_SEARCH)
         searches_sent++;
   endtask

   task automatic write_entry(input int idx, input logic signed [KEY_WIDTH-1:0] val);
      drive_request(OP_WRITE, INDEX_WIDTH'(idx), val);
      loaded_values[idx] = val;
   endtask

   // a write gives no response, so the drain alone does not prove the block idle
   task automatic load_count(input int span);
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= COUNT_WIDTH'(span);
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      current_span = (span > TABLE_DEPTH) ? TABLE_DEPTH : span;
      count_settings++;
   endtask

   task automatic fill_entries(input int n);
      longint                      step_max;
      longint                      free_room;
      longint                      acc;
      logic signed [KEY_WIDTH-1:0] v;
      int                          shape;
      shape = $urandom_range(0, 9);
      case ($urandom_range(0, 2))
         0: begin
            step_max = 3;
         end
         1: begin
            step_max = 1000;
         end
         default: begin
            step_max = 64'd1 << 23;
         end
      endcase
      free_room = (64'sd1 << 32) - longint'(n) * step_max;
      acc = -(64'sd1 << 31) + longint'({32'd0, $urandom_range(32'(free_room - 1), 0)});
      for (int i = 0; i < n; i++) begin
         if (shape < 2) begin
            // unsorted content, the probe path is taken as it falls
            v = $urandom;
         end else begin
            v = KEY_WIDTH'(acc);
            acc += longint'({32'd0, $urandom_range(32'(step_max), 0)});
            if (shape >= 7 && i == 0)
               v = KEY_MIN;
            if (shape >= 7 && i == n - 1)
               v = KEY_MAX;
         end
         write_entry(i, v);
      end
   endtask

   function automatic logic signed [KEY_WIDTH-1:0] pick_key();
      int                          pick;
      int                          idx;
      logic signed [KEY_WIDTH-1:0] k;
      pick = $urandom_range(0, 99);
      idx  = (current_span > 0) ? $urandom_range(current_span - 1, 0) : 0;
      if (current_span > 0 && pick < 50) begin
         k = loaded_values[idx];
      end else if (current_span > 0 && pick < 70) begin
         k = loaded_values[idx] + ($urandom_range(0, 1) ? 32'sd1 : -32'sd1);
      end else if (pick < 85) begin
         k = $urandom;
      end else begin
         case ($urandom_range(0, 2))
            0: begin
               k = KEY_MIN;
            end
            1: begin
               k = KEY_MAX;
            end
            default: begin
               k = '0;
            end
         endcase
      end
      return k;
   endfunction

   initial begin
      int                          span;
      int                          pick;
      int                          phase_no;
      logic [INDEX_WIDTH-1:0]      idx;
      logic signed [KEY_WIDTH-1:0] val;

      reset              <= 1'b1;
      csr_wr_en          <= 1'b0;
      csr_wr_data        <= '0;
      req_ch.valid       <= 1'b0;
      req_ch.operation   <= OP_WRITE;
      req_ch.entry_index <= '0;
      req_ch.value       <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // empty table straight out of reset
      drive_request(OP_SEARCH, 8'hff, KEY_MIN);
      for (int i = 0; i < 7; i++)
         write_entry(i, SEED_ROW[i]);
      load_count(7);
      drive_request(OP_SEARCH, 8'h00, KEY_MIN);
      drive_request(OP_SEARCH, 8'hff, KEY_MAX);
      drive_request(OP_SEARCH, 8'h5a, 32'sd7);
      drive_request(OP_SEARCH, 8'ha5, 32'sd0);
      drive_request(OP_SEARCH, 8'h01, -32'sd5);
      drive_request(OP_SEARCH, 8'h80, 32'sd8);
      drive_request(OP_SEARCH, 8'h7f, KEY_MIN + 32'sd1);
      drive_request(OP_SEARCH, 8'h33, KEY_MAX - 32'sd1);
      load_count(1);
      drive_request(OP_SEARCH, 8'h00, KEY_MIN);
      drive_request(OP_SEARCH, 8'h00, 32'sd0);
      load_count(0);
      drive_request(OP_SEARCH, 8'hcc, 32'sd7);

      // full table first, then a count beyond the depth, then mostly small tables
      phase_no = 0;
      while (items_sent < TOTAL_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (phase_no == 0)
            span = TABLE_DEPTH;
         else if (phase_no == 1)
            span = $urandom_range(511, TABLE_DEPTH + 1);
         else if (pick < 8)
            span = 0;
         else if (pick < 70)
            span = $urandom_range(16, 1);
         else if (pick < 96)
            span = $urandom_range(64, 17);
         else if (pick < 98)
            span = TABLE_DEPTH;
         else
            span = $urandom_range(511, TABLE_DEPTH + 1);
         phase_no++;
         load_count(span);
         fill_entries(current_span);
         repeat ($urandom_range(40, 8)) begin
            if ($urandom_range(0, 9) == 0) begin
               // stray write, may break the ordering
               idx = $urandom;
               val = $urandom;
               write_entry(int'(idx), val);
            end else begin
               drive_request(OP_SEARCH, INDEX_WIDTH'($urandom), pick_key());
            end
         end
      end

      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d transactions: %0d searches, %0d hits, %0d entry count settings",
               items_sent, searches_sent, hit_count, count_settings);
      $display("tables sorted, duplicated, unsorted and at the key extremes, under mixed stalls");
      if (fail_count == 0 && pending == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

### binary_search_sorted_table.f
hw/rtl/bsst_pkg.sv
hw/rtl/bsst_req_if.sv
hw/rtl/bsst_rsp_if.sv
hw/rtl/bsst_ram.sv
hw/rtl/binary_search_sorted_table.sv
tb/bsst_search_checker.sv
tb/tb_binary_search_sorted_table.sv
